>>> sv/point_to_plane_residual_jacobian_top_macros.svh
// Assertion macros for the point-to-plane residual block.
// Expects clk and rst_n in the scope of each use.
`ifndef POINT_TO_PLANE_RESIDUAL_JACOBIAN_TOP_MACROS_SVH
`define POINT_TO_PLANE_RESIDUAL_JACOBIAN_TOP_MACROS_SVH

// Condition must imply the consequence in the same cycle
`define P2P_ASSERT_IMPLY(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition must never hold
`define P2P_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> sv/p2p_pkg.sv
// Package for the point-to-plane residual block: word types, register
// indexes, fixed-point constants and saturation. No dependencies.
package p2p_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int WN_SHIFT        = 60 - COORD_FRAC_BITS;

    typedef logic signed [47:0] acc_t;

    localparam acc_t ONE_Q30 = 48'sd1073741824;

    typedef enum logic [2:0] {
        CFG_POSE_TX = 3'd0,
        CFG_POSE_TY = 3'd1,
        CFG_POSE_TZ = 3'd2,
        CFG_QUAT_X  = 3'd3,
        CFG_QUAT_Y  = 3'd4,
        CFG_QUAT_Z  = 3'd5,
        CFG_QUAT_W  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] plane_offset;
        logic        [30:0] weight;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] residual;
        logic signed [31:0] jac_tx;
        logic signed [31:0] jac_ty;
        logic signed [31:0] jac_tz;
        logic signed [31:0] jac_rx;
        logic signed [31:0] jac_ry;
        logic signed [31:0] jac_rz;
    } out_word_t;

    // Clamp a wide value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> sv/p2p_mul.sv
// Split fixed-point multiplier: floor(a*b / 2^30) from two partial products.
// Depends on p2p_pkg. Partials are registered; the recombine is combinational.
module p2p_mul
    import p2p_pkg::*;
(
    input  logic               clk,
    input  acc_t               a,
    input  logic signed [31:0] b,
    output acc_t               y
);

    logic signed [32:0] a_hi;
    logic signed [15:0] a_lo;
    logic signed [64:0] hi_prod;
    logic signed [47:0] lo_prod;
    logic signed [63:0] hi_reg;
    logic signed [47:0] lo_reg;
    logic signed [63:0] lo_ext;
    logic signed [63:0] sum;

    // Cut the wide operand into a signed high part and a 15-bit low part
    assign a_hi    = $signed(a[47:15]);
    assign a_lo    = $signed({1'b0, a[14:0]});
    assign hi_prod = a_hi * b;
    assign lo_prod = a_lo * b;

    // Hold the partial products
    always_ff @(posedge clk)
    begin
        hi_reg <= hi_prod[63:0];
        lo_reg <= lo_prod;
    end

    // Recombine with floor rounding
    assign lo_ext = 64'(lo_reg) >>> 15;
    assign sum    = hi_reg + lo_ext;
    assign y      = sum[62:15];

endmodule

>>> sv/point_to_plane_residual_jacobian_top.sv
// Point-to-plane residual with pose Jacobian, eight-stage pipeline.
// A word taken with start shows on out together with done after the last stage.
// Throughput: one word per cycle; busy stays low, start is never refused.
// The receiver cannot stall; results stream out one per accepted word.
// Reset clears the pose to identity and all stage valid bits.
// Depends on p2p_pkg, p2p_mul and the assertion macro header.
`include "point_to_plane_residual_jacobian_top_macros.svh"

module point_to_plane_residual_jacobian_top
    import p2p_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_word_t    in,
    output logic        done,
    output out_word_t   out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data
);

    // Pose registers
    logic signed [31:0] pose_tx_reg, pose_ty_reg, pose_tz_reg;
    logic signed [31:0] quat_x_reg, quat_y_reg, quat_z_reg, quat_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_tx_reg <= '0;
            pose_ty_reg <= '0;
            pose_tz_reg <= '0;
            quat_x_reg  <= '0;
            quat_y_reg  <= '0;
            quat_z_reg  <= '0;
            quat_w_reg  <= 32'sh40000000;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_POSE_TX: pose_tx_reg <= cfg_data;
                CFG_POSE_TY: pose_ty_reg <= cfg_data;
                CFG_POSE_TZ: pose_tz_reg <= cfg_data;
                CFG_QUAT_X:  quat_x_reg  <= cfg_data;
                CFG_QUAT_Y:  quat_y_reg  <= cfg_data;
                CFG_QUAT_Z:  quat_z_reg  <= cfg_data;
                CFG_QUAT_W:  quat_w_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Valid bits, one per register stage
    logic [8:1] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[7:1], start & ~busy};
    end

    // Stage 1: quaternion products, floor(a*b / 2^29)
    logic signed [63:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
    logic signed [34:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [34:0] wx_reg, wy_reg, wz_reg;
    in_word_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;

    assign p_xx = quat_x_reg * quat_x_reg;
    assign p_yy = quat_y_reg * quat_y_reg;
    assign p_zz = quat_z_reg * quat_z_reg;
    assign p_xy = quat_x_reg * quat_y_reg;
    assign p_xz = quat_x_reg * quat_z_reg;
    assign p_yz = quat_y_reg * quat_z_reg;
    assign p_wx = quat_w_reg * quat_x_reg;
    assign p_wy = quat_w_reg * quat_y_reg;
    assign p_wz = quat_w_reg * quat_z_reg;

    always_ff @(posedge clk)
    begin
        xx_reg <= p_xx[63:29];
        yy_reg <= p_yy[63:29];
        zz_reg <= p_zz[63:29];
        xy_reg <= p_xy[63:29];
        xz_reg <= p_xz[63:29];
        yz_reg <= p_yz[63:29];
        wx_reg <= p_wx[63:29];
        wy_reg <= p_wy[63:29];
        wz_reg <= p_wz[63:29];
        s1_reg <= in;
    end

    // Stage 2: rotation matrix
    acc_t r_reg [3][3];
    always_ff @(posedge clk)
    begin
        r_reg[0][0] <= ONE_Q30 - 48'(yy_reg) - 48'(zz_reg);
        r_reg[0][1] <= 48'(xy_reg) - 48'(wz_reg);
        r_reg[0][2] <= 48'(xz_reg) + 48'(wy_reg);
        r_reg[1][0] <= 48'(xy_reg) + 48'(wz_reg);
        r_reg[1][1] <= ONE_Q30 - 48'(xx_reg) - 48'(zz_reg);
        r_reg[1][2] <= 48'(yz_reg) - 48'(wx_reg);
        r_reg[2][0] <= 48'(xz_reg) - 48'(wy_reg);
        r_reg[2][1] <= 48'(yz_reg) + 48'(wx_reg);
        r_reg[2][2] <= ONE_Q30 - 48'(xx_reg) - 48'(yy_reg);
        s2_reg      <= s1_reg;
    end

    // Stage 3: R*p and R^T*n partial products
    logic signed [31:0] s2_p [3];
    logic signed [31:0] s2_n [3];
    acc_t y_rp [3][3];
    acc_t y_rn [3][3];

    assign s2_p[0] = s2_reg.point_x;
    assign s2_p[1] = s2_reg.point_y;
    assign s2_p[2] = s2_reg.point_z;
    assign s2_n[0] = s2_reg.normal_x;
    assign s2_n[1] = s2_reg.normal_y;
    assign s2_n[2] = s2_reg.normal_z;

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_row
        for (genvar gj = 0; gj < 3; gj++)
        begin : g_col
            p2p_mul u_rp (.clk(clk), .a(r_reg[gi][gj]), .b(s2_p[gj]), .y(y_rp[gi][gj]));
            p2p_mul u_rn (.clk(clk), .a(r_reg[gj][gi]), .b(s2_n[gj]), .y(y_rn[gi][gj]));
        end
    end

    always_ff @(posedge clk)
    begin
        s3_reg <= s2_reg;
    end

    // Stage 4: transformed point and R^T n
    acc_t pc_reg [3];
    acc_t m_reg  [3];
    always_ff @(posedge clk)
    begin
        pc_reg[0] <= 48'(pose_tx_reg) + y_rp[0][0] + y_rp[0][1] + y_rp[0][2];
        pc_reg[1] <= 48'(pose_ty_reg) + y_rp[1][0] + y_rp[1][1] + y_rp[1][2];
        pc_reg[2] <= 48'(pose_tz_reg) + y_rp[2][0] + y_rp[2][1] + y_rp[2][2];
        for (int i = 0; i < 3; i++)
        begin
            m_reg[i] <= y_rn[i][0] + y_rn[i][1] + y_rn[i][2];
        end
        s4_reg <= s3_reg;
    end

    // Stage 5: distance and cross-product partials
    acc_t y_pn [3];
    acc_t y_cr [6];
    p2p_mul u_pn0 (.clk(clk), .a(pc_reg[0]), .b(s4_reg.normal_x), .y(y_pn[0]));
    p2p_mul u_pn1 (.clk(clk), .a(pc_reg[1]), .b(s4_reg.normal_y), .y(y_pn[1]));
    p2p_mul u_pn2 (.clk(clk), .a(pc_reg[2]), .b(s4_reg.normal_z), .y(y_pn[2]));
    p2p_mul u_cr0 (.clk(clk), .a(m_reg[2]), .b(s4_reg.point_y), .y(y_cr[0]));
    p2p_mul u_cr1 (.clk(clk), .a(m_reg[1]), .b(s4_reg.point_z), .y(y_cr[1]));
    p2p_mul u_cr2 (.clk(clk), .a(m_reg[0]), .b(s4_reg.point_z), .y(y_cr[2]));
    p2p_mul u_cr3 (.clk(clk), .a(m_reg[2]), .b(s4_reg.point_x), .y(y_cr[3]));
    p2p_mul u_cr4 (.clk(clk), .a(m_reg[1]), .b(s4_reg.point_x), .y(y_cr[4]));
    p2p_mul u_cr5 (.clk(clk), .a(m_reg[0]), .b(s4_reg.point_y), .y(y_cr[5]));

    always_ff @(posedge clk)
    begin
        s5_reg <= s4_reg;
    end

    // Stage 6: unweighted distance and cross product
    acc_t dist_reg;
    acc_t c_reg [3];
    always_ff @(posedge clk)
    begin
        dist_reg <= 48'(s5_reg.plane_offset) + y_pn[0] + y_pn[1] + y_pn[2];
        c_reg[0] <= y_cr[0] - y_cr[1];
        c_reg[1] <= y_cr[2] - y_cr[3];
        c_reg[2] <= y_cr[4] - y_cr[5];
        s6_reg   <= s5_reg;
    end

    // Stage 7: weighting partials and translation terms
    logic signed [31:0] w_s;
    acc_t y_ws;
    acc_t y_wc [3];
    logic signed [63:0] wn_reg [3];

    assign w_s = $signed({1'b0, s6_reg.weight});

    p2p_mul u_ws  (.clk(clk), .a(dist_reg), .b(w_s), .y(y_ws));
    p2p_mul u_wc0 (.clk(clk), .a(c_reg[0]), .b(w_s), .y(y_wc[0]));
    p2p_mul u_wc1 (.clk(clk), .a(c_reg[1]), .b(w_s), .y(y_wc[1]));
    p2p_mul u_wc2 (.clk(clk), .a(c_reg[2]), .b(w_s), .y(y_wc[2]));

    always_ff @(posedge clk)
    begin
        wn_reg[0] <= w_s * s6_reg.normal_x;
        wn_reg[1] <= w_s * s6_reg.normal_y;
        wn_reg[2] <= w_s * s6_reg.normal_z;
    end

    // Stage 8: saturate into the output word
    out_word_t out_reg;
    always_ff @(posedge clk)
    begin
        out_reg.residual <= sat32(64'(y_ws));
        out_reg.jac_tx   <= sat32(wn_reg[0] >>> WN_SHIFT);
        out_reg.jac_ty   <= sat32(wn_reg[1] >>> WN_SHIFT);
        out_reg.jac_tz   <= sat32(wn_reg[2] >>> WN_SHIFT);
        out_reg.jac_rx   <= sat32(64'(y_wc[0]));
        out_reg.jac_ry   <= sat32(64'(y_wc[1]));
        out_reg.jac_rz   <= sat32(64'(y_wc[2]));
    end

    assign out  = out_reg;
    assign done = v_reg[8];

    // A result word only follows a word that was taken with start
    `P2P_ASSERT_IMPLY(a_done_src, done, $past(start, 8), "result without source word")
    // A zero weight gives an all-zero result word
    `P2P_ASSERT_IMPLY(a_zero_wt, done && $past(in.weight == 31'd0, 8),
        out == '0, "zero weight gave nonzero result")
    // The block never refuses a word
    `P2P_ASSERT_NEVER(a_no_busy, busy, "busy raised")

endmodule
